// ===== rtl/dwmd_pkg.sv =====
// Shared constants and control structs for the distinct window marker detector.
package dwmd_pkg;

    localparam int MARKER_LENGTH_W = 5;
    localparam logic [MARKER_LENGTH_W-1:0] MARKER_LENGTH_RESET = 5'd4;

    localparam logic [7:0] CHAR_A = 8'h61;
    localparam logic [7:0] CHAR_Z = 8'h7a;

    localparam int POSITION_W = 32;
    localparam logic [POSITION_W-1:0] POSITION_MAX = '1;

    // write request from the tracker to the last-seen store
    typedef struct packed {
        logic wr_en;
        logic clear_all;
    } t_store_ctl;

    // what the store knows about the previous occurrence of the read letter
    typedef struct packed {
        logic valid;
        logic fwd;
    } t_prev_info;

endpackage

// ===== rtl/dwmd_pos_store.sv =====
// Last-seen position memory per letter, with valid bits, bypass flag and aging sweep.
module dwmd_pos_store #(
    parameter int WINDOW_MAX = 16,
    parameter int ALPHABET_SIZE = 26,
    localparam int LETTER_W = $clog2(ALPHABET_SIZE),
    localparam int AGE_W = $clog2(WINDOW_MAX + ALPHABET_SIZE + 4) + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dwmd_pkg::t_store_ctl  i_ctl,
    input  logic [LETTER_W-1:0]   i_wr_addr,
    input  logic [AGE_W-1:0]      i_wr_pos,
    input  logic                  i_rd_en,
    input  logic [LETTER_W-1:0]   i_rd_addr,
    input  logic [AGE_W-1:0]      i_cur_pos,
    output logic [AGE_W-1:0]      o_rd_pos,
    output dwmd_pkg::t_prev_info  o_rd_info
);

    logic [AGE_W-1:0] mem [ALPHABET_SIZE];

    logic [AGE_W-1:0]         r_rd_pos;
    logic [LETTER_W-1:0]      r_rd_addr;
    logic                     r_fwd;
    logic [ALPHABET_SIZE-1:0] r_valid;
    logic [ALPHABET_SIZE-1:0] n_valid;
    logic [LETTER_W-1:0]      r_sweep;
    logic [LETTER_W-1:0]      n_sweep;
    logic [LETTER_W-1:0]      r_sw_idx;
    logic [AGE_W-1:0]         r_sw_pos;
    logic                     r_sw_guard;
    logic [AGE_W-1:0]         sw_age;
    logic                     sw_clr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_pos;
        end
        if (i_rd_en) begin
            r_rd_pos <= mem[i_rd_addr];
        end
        r_sw_pos <= mem[r_sweep];
    end

    // entries older than the window are dropped so the short position never aliases
    assign sw_age = i_cur_pos - r_sw_pos;
    assign sw_clr = r_valid[r_sw_idx] && !r_sw_guard && (sw_age >= AGE_W'(WINDOW_MAX));

    always_comb begin
        n_sweep = (r_sweep == LETTER_W'(ALPHABET_SIZE - 1)) ? '0 : r_sweep + 1'b1;
        n_valid = r_valid;
        if (sw_clr) begin
            n_valid[r_sw_idx] = 1'b0;
        end
        if (i_ctl.wr_en) begin
            n_valid[i_wr_addr] = 1'b1;
        end
        if (i_ctl.clear_all) begin
            n_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_sweep    <= '0;
            r_sw_idx   <= '0;
            r_sw_guard <= 1'b1;
            r_rd_addr  <= '0;
            r_fwd      <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_sweep    <= n_sweep;
            r_sw_idx   <= r_sweep;
            // sweep data read at the same edge as a write to that entry is stale
            r_sw_guard <= i_ctl.wr_en && (i_wr_addr == r_sweep);
            if (i_rd_en) begin
                r_rd_addr <= i_rd_addr;
                r_fwd     <= i_ctl.wr_en && !i_ctl.clear_all && (i_wr_addr == i_rd_addr);
            end
        end
    end

    assign o_rd_pos        = r_rd_pos;
    assign o_rd_info.valid = r_valid[r_rd_addr];
    assign o_rd_info.fwd   = r_fwd;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.clear_all |=> (r_valid == '0))
        else $error("valid bits not cleared at end of stream");

    a_write_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.wr_en && !i_ctl.clear_all) |=> r_valid[$past(i_wr_addr)])
        else $error("written entry not marked valid");

endmodule

// ===== rtl/dwmd_track.sv =====
// Distinct-run, window fill, stream position tracking; one commit per cycle.
module dwmd_track #(
    parameter int WINDOW_MAX = 16,
    parameter int ALPHABET_SIZE = 26,
    localparam int LEN_W = $clog2(WINDOW_MAX + 1),
    localparam int AGE_W = $clog2(WINDOW_MAX + ALPHABET_SIZE + 4) + 1
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_commit,
    input  logic                              i_last,
    input  logic [LEN_W-1:0]                  i_len,
    input  logic [AGE_W-1:0]                  i_prev_pos,
    input  dwmd_pkg::t_prev_info              i_prev,
    output logic                              o_found,
    output logic                              o_not_found,
    output logic [dwmd_pkg::POSITION_W-1:0]   o_position,
    output dwmd_pkg::t_store_ctl              o_ctl,
    output logic [AGE_W-1:0]                  o_wr_pos,
    output logic [AGE_W-1:0]                  o_cur_pos
);

    logic [LEN_W-1:0]                r_run;
    logic [LEN_W-1:0]                n_run;
    logic [LEN_W-1:0]                r_held;
    logic [LEN_W-1:0]                n_held;
    logic                            r_seen;
    logic                            n_seen;
    logic [AGE_W-1:0]                r_ipos;
    logic [AGE_W-1:0]                n_ipos;
    logic [dwmd_pkg::POSITION_W-1:0] r_pos;
    logic [dwmd_pkg::POSITION_W-1:0] n_pos;
    logic [dwmd_pkg::POSITION_W-1:0] pos_inc;
    logic [AGE_W-1:0]                item_pos;
    logic [AGE_W-1:0]                prev_gap;
    logic [LEN_W-1:0]                run_inc;
    logic [LEN_W-1:0]                run_new;
    logic [LEN_W:0]                  held_inc;
    logic                            has_prev;
    logic                            full;
    logic                            found;

    assign item_pos = r_ipos + 1'b1;
    // previous item wrote this letter at the edge of our read: it sits one back
    assign prev_gap = i_prev.fwd ? AGE_W'(1) : item_pos - i_prev_pos;
    assign has_prev = i_prev.fwd | i_prev.valid;
    assign run_inc  = (r_run == LEN_W'(WINDOW_MAX)) ? r_run : r_run + 1'b1;
    assign run_new  = (has_prev && (prev_gap < AGE_W'(run_inc))) ? LEN_W'(prev_gap) : run_inc;
    assign held_inc = {1'b0, r_held} + 1'b1;
    assign full     = (held_inc >= {1'b0, i_len});
    assign found    = !r_seen && full && (run_new >= i_len);
    assign pos_inc  = (r_pos == dwmd_pkg::POSITION_MAX) ? r_pos : r_pos + 1'b1;

    always_comb begin
        n_run  = r_run;
        n_held = r_held;
        n_seen = r_seen;
        n_ipos = r_ipos;
        n_pos  = r_pos;
        if (i_commit) begin
            if (i_last) begin
                n_run  = '0;
                n_held = '0;
                n_seen = 1'b0;
                n_ipos = '0;
                n_pos  = '0;
            end else begin
                n_ipos = item_pos;
                n_pos  = pos_inc;
                if (!r_seen) begin
                    n_run  = run_new;
                    // a full window keeps len-1 after dropping the oldest
                    n_held = full ? i_len - 1'b1 : held_inc[LEN_W-1:0];
                    n_seen = found;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= '0;
            r_held <= '0;
            r_seen <= 1'b0;
            r_ipos <= '0;
            r_pos  <= '0;
        end else begin
            r_run  <= n_run;
            r_held <= n_held;
            r_seen <= n_seen;
            r_ipos <= n_ipos;
            r_pos  <= n_pos;
        end
    end

    assign o_found         = found;
    assign o_not_found     = i_last && !r_seen && !found;
    assign o_position      = pos_inc;
    assign o_ctl.wr_en     = i_commit && !r_seen;
    assign o_ctl.clear_all = i_commit && i_last;
    assign o_wr_pos        = item_pos;
    assign o_cur_pos       = r_ipos;

    a_held_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held < LEN_W'(WINDOW_MAX))
        else $error("window fill count out of range");

    a_found_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_commit && o_found) |-> (o_position >= dwmd_pkg::POSITION_W'(i_len)))
        else $error("marker found before enough items");

endmodule

// ===== rtl/distinct_window_marker_detect_unit.sv =====
// Top level: symbol mapping, stage and output registers, configuration register.
// An accepted item is registered in the stage register, its result in the output register.
// Throughput: one item per cycle while not stalled; the last-seen position memory is read
// at accept and written on commit, with a bypass for the same letter in back-to-back items.
// Reset (synchronous, active low) empties the pipeline, clears stream state and valid bits,
// and sets marker_length to 4; memory contents are not cleared and no item waits on reset.
module distinct_window_marker_detect_unit #(
    parameter int WINDOW_MAX = 16,
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [dwmd_pkg::MARKER_LENGTH_W-1:0]   i_cfg_wdata,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [7:0]                             i_symbol,
    input  logic                                   i_last_symbol,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_found,
    output logic [dwmd_pkg::POSITION_W-1:0]        o_position,
    output logic                                   o_not_found
);

    localparam int LETTER_W = $clog2(ALPHABET_SIZE);
    localparam int LEN_W    = $clog2(WINDOW_MAX + 1);
    localparam int AGE_W    = $clog2(WINDOW_MAX + ALPHABET_SIZE + 4) + 1;
    localparam int CMP_W    = (LEN_W > dwmd_pkg::MARKER_LENGTH_W) ?
                              LEN_W : dwmd_pkg::MARKER_LENGTH_W;

    logic [dwmd_pkg::MARKER_LENGTH_W-1:0] r_marker_length;
    logic [CMP_W-1:0]                     len_raw;
    logic [CMP_W-1:0]                     len_clamped;
    logic [LEN_W-1:0]                     len_eff;

    logic [7:0]          sym_ofs;
    logic                sym_letter;
    logic [LETTER_W-1:0] letter;

    logic                r_s1_valid;
    logic [LETTER_W-1:0] r_s1_letter;
    logic                r_s1_last;

    logic                            r_out_valid;
    logic                            r_found;
    logic [dwmd_pkg::POSITION_W-1:0] r_position;
    logic                            r_not_found;

    logic advance;
    logic s1_go;
    logic in_accept;

    logic                            trk_found;
    logic                            trk_not_found;
    logic [dwmd_pkg::POSITION_W-1:0] trk_position;
    dwmd_pkg::t_store_ctl            store_ctl;
    dwmd_pkg::t_prev_info            prev_info;
    logic [AGE_W-1:0]                wr_pos;
    logic [AGE_W-1:0]                cur_pos;
    logic [AGE_W-1:0]                prev_pos;

    // zero acts as one, anything above the window acts as the window
    always_comb begin
        len_raw = CMP_W'(r_marker_length);
        if (len_raw == '0) begin
            len_clamped = CMP_W'(1);
        end else if (len_raw > CMP_W'(WINDOW_MAX)) begin
            len_clamped = CMP_W'(WINDOW_MAX);
        end else begin
            len_clamped = len_raw;
        end
    end
    assign len_eff = LEN_W'(len_clamped);

    // bytes that are not a letter of the alphabet count as the first letter
    assign sym_ofs    = i_symbol - dwmd_pkg::CHAR_A;
    assign sym_letter = (i_symbol >= dwmd_pkg::CHAR_A) && (i_symbol <= dwmd_pkg::CHAR_Z) &&
                        (sym_ofs < 8'(ALPHABET_SIZE));
    assign letter     = sym_letter ? LETTER_W'(sym_ofs) : '0;

    assign advance   = !r_out_valid || !i_stall;
    assign s1_go     = r_s1_valid && advance;
    assign o_stall   = r_s1_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker_length <= dwmd_pkg::MARKER_LENGTH_RESET;
        end else if (i_cfg_we) begin
            r_marker_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_letter <= letter;
            r_s1_last   <= i_last_symbol;
        end
        if (s1_go) begin
            r_found     <= trk_found;
            r_position  <= trk_position;
            r_not_found <= trk_not_found;
        end
    end

    dwmd_pos_store #(
        .WINDOW_MAX    (WINDOW_MAX),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_wr_addr (r_s1_letter),
        .i_wr_pos  (wr_pos),
        .i_rd_en   (in_accept),
        .i_rd_addr (letter),
        .i_cur_pos (cur_pos),
        .o_rd_pos  (prev_pos),
        .o_rd_info (prev_info)
    );

    dwmd_track #(
        .WINDOW_MAX    (WINDOW_MAX),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_commit    (s1_go),
        .i_last      (r_s1_last),
        .i_len       (len_eff),
        .i_prev_pos  (prev_pos),
        .i_prev      (prev_info),
        .o_found     (trk_found),
        .o_not_found (trk_not_found),
        .o_position  (trk_position),
        .o_ctl       (store_ctl),
        .o_wr_pos    (wr_pos),
        .o_cur_pos   (cur_pos)
    );

    assign o_valid     = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;
    assign o_not_found = r_not_found;

    a_found_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_found && r_not_found))
        else $error("found and not_found on the same item");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_s1_letter)))
        else $error("held item lost from stage register");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go |=> r_out_valid)
        else $error("committed item missing at output");

endmodule

// ===== tb/distinct_window_marker_detect_unit_tb.sv =====
// Self-checking testbench for the distinct window marker detector.
module distinct_window_marker_detect_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW_MAX = 16;
    localparam int ALPHABET_SIZE = 26;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        logic [7:0] sym;
        logic       last;
    } t_symbol_item;

    typedef struct {
        logic                            found;
        logic [dwmd_pkg::POSITION_W-1:0] position;
        logic                            not_found;
    } t_marker_result;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 i_cfg_we = 1'b0;
    logic [dwmd_pkg::MARKER_LENGTH_W-1:0] i_cfg_wdata = '0;
    logic                                 i_valid = 1'b0;
    logic                                 o_stall;
    logic [7:0]                           i_symbol = '0;
    logic                                 i_last_symbol = 1'b0;
    logic                                 o_valid;
    logic                                 i_stall = 1'b0;
    logic                                 o_found;
    logic [dwmd_pkg::POSITION_W-1:0]      o_position;
    logic                                 o_not_found;

    distinct_window_marker_detect_unit #(
        .WINDOW_MAX(WINDOW_MAX),
        .ALPHABET_SIZE(ALPHABET_SIZE)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_symbol(i_symbol),
        .i_last_symbol(i_last_symbol),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_found(o_found),
        .o_position(o_position),
        .o_not_found(o_not_found)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state
    int                              marker_len = dwmd_pkg::MARKER_LENGTH_RESET;
    int                              letter_cnt[ALPHABET_SIZE];
    int                              single_cnt;
    logic [4:0]                      win_hist[WINDOW_MAX];
    int                              win_wptr;
    int                              win_held;
    logic [dwmd_pkg::POSITION_W-1:0] stream_pos;
    bit                              marker_hit;

    t_symbol_item   pending_q[$];
    t_marker_result result_q[$];

    bit idle_on = 1'b1;
    int hold_req = 0;
    int hold_done = 0;
    int hold_left = 0;
    int err_count = 0;
    int sent_count = 0;
    int checked_count = 0;
    int found_count = 0;
    int stream_count = 0;
    int idle_cycles = 0;
    t_marker_result want;

    function automatic int eff_length();
        if (marker_len < 1) return 1;
        if (marker_len > WINDOW_MAX) return WINDOW_MAX;
        return marker_len;
    endfunction

    function automatic void clear_stream();
        foreach (letter_cnt[k]) letter_cnt[k] = 0;
        single_cnt = 0;
        win_wptr = 0;
        win_held = 0;
        stream_pos = '0;
        marker_hit = 1'b0;
    endfunction

    function automatic void retire_oldest();
        int idx;
        int k;
        if (win_held == 0) return;
        idx = (win_wptr + WINDOW_MAX - win_held) % WINDOW_MAX;
        k = win_hist[idx];
        win_held--;
        if (letter_cnt[k] == 0) return;
        letter_cnt[k]--;
        if (letter_cnt[k] == 0) begin
            if (single_cnt > 0) single_cnt--;
        end else if (letter_cnt[k] == 1) begin
            single_cnt++;
        end
    endfunction

    function automatic t_marker_result predict_marker(t_symbol_item it);
        t_marker_result r;
        int len;
        int k;
        len = eff_length();
        r.found = 1'b0;
        if (stream_pos != dwmd_pkg::POSITION_MAX) stream_pos++;
        if (!marker_hit) begin
            k = (it.sym >= dwmd_pkg::CHAR_A && it.sym <= dwmd_pkg::CHAR_Z) ?
                int'(it.sym - dwmd_pkg::CHAR_A) : 0;
            win_hist[win_wptr] = 5'(k);
            win_wptr = (win_wptr + 1) % WINDOW_MAX;
            if (win_held < WINDOW_MAX) win_held++;
            letter_cnt[k]++;
            if (letter_cnt[k] == 1) single_cnt++;
            else if (letter_cnt[k] == 2 && single_cnt > 0) single_cnt--;
            while (win_held > len) retire_oldest();
            if (win_held == len && single_cnt == len) begin
                r.found = 1'b1;
                marker_hit = 1'b1;
            end else if (win_held == len) begin
                // window kept one short, so the next symbol completes a candidate
                retire_oldest();
            end
        end
        r.position = stream_pos;
        r.not_found = it.last && !marker_hit;
        if (it.last) clear_stream();
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (err_count < 50) $display("[%0t] mismatch: %s", $time, what);
        err_count++;
    endtask

    // ---------------------------------------------------------------
    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                result_q.push_back(predict_marker('{i_symbol, i_last_symbol}));
                sent_count++;
                if (i_last_symbol) stream_count++;
            end
            if (!i_valid || !o_stall) begin
                if (pending_q.size() != 0 && !(idle_on && $urandom_range(99) < 33)) begin
                    i_valid <= 1'b1;
                    i_symbol <= pending_q[0].sym;
                    i_last_symbol <= pending_q[0].last;
                    void'(pending_q.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                checked_count++;
                if (result_q.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = result_q.pop_front();
                    if (want.found) found_count++;
                    if (o_found !== want.found)
                        report_mismatch($sformatf("found got %b exp %b (pos %0d)",
                                                  o_found, want.found, want.position));
                    if (o_position !== want.position)
                        report_mismatch($sformatf("position got %0d exp %0d",
                                                  o_position, want.position));
                    if (o_not_found !== want.not_found)
                        report_mismatch($sformatf("not_found got %b exp %b (pos %0d)",
                                                  o_not_found, want.not_found,
                                                  want.position));
                end
            end
            if (hold_left == 0 && hold_done != hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_done = hold_req;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= idle_on && ($urandom_range(99) < 33);
            end
        end
    end

    // Watchdog: no handshake on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", idle_cycles);
            $display("distinct_window_marker_detect_unit_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || i_valid || result_q.size() != 0);
    endtask

    task automatic write_length(int v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= dwmd_pkg::MARKER_LENGTH_W'(v);
        marker_len = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic push_text(string s, bit close);
        for (int j = 0; j < s.len(); j++)
            pending_q.push_back('{s[j], close && (j == s.len() - 1)});
    endtask

    // Mostly well-formed streams: in some modes a planted run of distinct letters
    // amid letters from a narrow or the full alphabet, plus some raw-byte noise.
    task automatic gen_stream(int n, bit close);
        int mode;
        int len;
        int start;
        int t;
        int r;
        int perm[ALPHABET_SIZE];
        logic [7:0] sym;
        mode = $urandom_range(9);
        len = eff_length();
        start = (n > len) ? $urandom_range(n - len) : 0;
        foreach (perm[k]) perm[k] = k;
        for (int k = ALPHABET_SIZE - 1; k > 0; k--) begin
            r = $urandom_range(k);
            t = perm[k];
            perm[k] = perm[r];
            perm[r] = t;
        end
        for (int j = 0; j < n; j++) begin
            if (mode < 5 && j >= start && j < start + len)
                sym = dwmd_pkg::CHAR_A + 8'(perm[j - start]);
            else if (mode == 9 || $urandom_range(9) == 0)
                sym = 8'($urandom_range(255));
            else
                sym = dwmd_pkg::CHAR_A +
                      8'($urandom_range(mode < 7 ? len : ALPHABET_SIZE - 1));
            pending_q.push_back('{sym, close && (j == n - 1)});
        end
    endtask

    initial begin
        int lengths[11];
        int quota;
        int n;
        lengths = '{1, 2, 3, 5, 16, 31, 17, 0, 8, 0, 4};
        clear_stream();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset length of 4, repeat before marker, symbols after marker
        push_text("aabcdzq", 1'b1);
        // bytes just outside the letter range and the byte extremes all map to 'a'
        pending_q.push_back('{8'h60, 1'b0});
        pending_q.push_back('{8'h7b, 1'b0});
        pending_q.push_back('{8'hff, 1'b0});
        pending_q.push_back('{8'h00, 1'b0});
        pending_q.push_back('{dwmd_pkg::CHAR_Z, 1'b1});
        push_text("m", 1'b1);
        wait_drained();
        // zero length behaves as one: single-symbol stream finds a marker
        write_length(0);
        push_text("b", 1'b1);
        wait_drained();
        // shrink the length in the middle of a stream
        write_length(4);
        push_text("abc", 1'b0);
        wait_drained();
        write_length(2);
        push_text("cd", 1'b1);
        wait_drained();
        // grow it mid-stream: leftover window is smaller than the new length
        push_text("xx", 1'b0);
        wait_drained();
        write_length(31);
        push_text("abcdefghijklmnopq", 1'b1);
        wait_drained();

        // random phases
        foreach (lengths[p]) begin
            write_length(p == 9 ? $urandom_range(1, WINDOW_MAX) : lengths[p]);
            idle_on = (p != 3);
            quota = 24;
            while (quota > 0) begin
                n = $urandom_range(1, 3 * eff_length() + 4);
                gen_stream(n, $urandom_range(9) != 0);
                quota -= n;
            end
            if (p == 5) hold_req++;
            wait_drained();
        end
        // close whatever stream is still open
        push_text("z", 1'b1);
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("%0d symbols in %0d closed streams, %0d results checked, %0d markers found",
                 sent_count, stream_count, checked_count, found_count);
        $display("lengths 0..31 incl. out of range, mid-stream length changes, one long hold-off");
        if (err_count == 0 && result_q.size() == 0) begin
            $display("distinct_window_marker_detect_unit_tb: PASS");
        end else begin
            $display("distinct_window_marker_detect_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== distinct_window_marker_detect_unit.f =====
rtl/dwmd_pkg.sv
rtl/dwmd_pos_store.sv
rtl/dwmd_track.sv
rtl/distinct_window_marker_detect_unit.sv
tb/distinct_window_marker_detect_unit_tb.sv
